>>> sv/sab_pkg.sv
// shared constants and types for the suffix array builder
package sab_pkg;

   localparam int POS_W = 12;
   localparam int LEN_W = 13;
   localparam int RND_W = 4;
   localparam int BYTE_W = 8;

   localparam logic ACT_APPEND = 1'b0;
   localparam logic ACT_READ = 1'b1;

   localparam logic KIND_REPORT = 1'b0;
   localparam logic KIND_READ = 1'b1;

   localparam logic [RND_W-1:0] RND_MAX = 4'hF;

   typedef struct packed {
      logic less;
      logic pair_eq;
   } cmp_res_type;

endpackage

>>> sv/sab_if.sv
// request and response channel interfaces
interface sab_req_if;
   logic valid;
   logic ready;
   logic action;
   logic [sab_pkg::BYTE_W-1:0] text_byte;
   logic last;
   logic [sab_pkg::POS_W-1:0] position;
   modport source (output valid, action, text_byte, last, position, input ready);
   modport sink (input valid, action, text_byte, last, position, output ready);
endinterface

interface sab_rsp_if;
   logic valid;
   logic ready;
   logic result_kind;
   logic [sab_pkg::POS_W-1:0] suffix_start;
   logic [sab_pkg::LEN_W-1:0] text_length;
   logic [sab_pkg::RND_W-1:0] rounds;
   logic error;
   modport source (output valid, result_kind, suffix_start, text_length, rounds, error,
                   input ready);
   modport sink (input valid, result_kind, suffix_start, text_length, rounds, error,
                 output ready);
endinterface

>>> sv/sab_ram.sv
// single write port, dual read port memory with registered read data
module sab_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr0,
   input  logic [$clog2(DEPTH)-1:0] raddr1,
   output logic [WIDTH-1:0]         rdata0,
   output logic [WIDTH-1:0]         rdata1
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata0_ff;
   logic [WIDTH-1:0] rdata1_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata0_ff <= mem[raddr0];
      rdata1_ff <= mem[raddr1];
   end

   assign rdata0 = rdata0_ff;
   assign rdata1 = rdata1_ff;
endmodule

>>> sv/sab_cmp.sv
// shared entry comparator: order on (first, second, start) and key pair equality
module sab_cmp #(
   parameter int EW = 38,
   parameter int AW = 12
) (
   input  logic [EW-1:0]             a,
   input  logic [EW-1:0]             b,
   output sab_pkg::cmp_res_type      res
);
   import sab_pkg::*;

   // entries are packed first key high, start low, so one compare gives the order
   always_comb begin
      res.less = a < b;
      res.pair_eq = a[EW-1:AW] == b[EW-1:AW];
   end
endmodule

>>> sv/suffix_array_builder.sv
// suffix array builder top level: text load, prefix doubling sequencer, read port
//
//  channel | dir | handshake      | payload
//  req_ch  | in  | valid / ready  | action, text_byte, last, position
//  rsp_ch  | out | valid / ready  | result_kind, suffix_start, text_length, rounds, error
//
// an append is written as it is accepted; a read waits in S_RDWAIT for the registered
// entry read and then puts its result out; a result is held until taken, and no transaction
// is accepted while a result waits or a build runs
// a build runs an init pass, then per round ceil(log2 n) merge passes and a ranking pass,
// with a refitting pass before each further round, all on one comparator and dual-port
// entry memories
// reset is synchronous and clears control state only; memories are not cleared
module suffix_array_builder #(
   parameter int MAX_LEN = 4096
) (
   input logic   clock,
   input logic   reset,
   sab_req_if.sink   req_ch,
   sab_rsp_if.source rsp_ch
);
   import sab_pkg::*;

   localparam int LW = $clog2(MAX_LEN + 1);
   localparam int AW = $clog2(MAX_LEN);
   localparam int CW = LW + 2;
   localparam int EW = 2 * LW + AW;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_RDWAIT = 4'd1;
   localparam logic [3:0] S_INIT_RD = 4'd2;
   localparam logic [3:0] S_INIT_WR = 4'd3;
   localparam logic [3:0] S_SORT = 4'd4;
   localparam logic [3:0] S_M_RD = 4'd5;
   localparam logic [3:0] S_M_WR = 4'd6;
   localparam logic [3:0] S_R_RD = 4'd7;
   localparam logic [3:0] S_R_WR = 4'd8;
   localparam logic [3:0] S_F_RD = 4'd9;
   localparam logic [3:0] S_F_RK = 4'd10;
   localparam logic [3:0] S_F_WR = 4'd11;
   localparam logic [3:0] S_DONE = 4'd12;

   logic [3:0]    state_ff, state_in;
   logic [LW-1:0] len_ff, len_in;
   logic          ovf_ff, ovf_in;
   logic          built_ff, built_in;
   logic [CW-1:0] gap_ff, gap_in;
   logic [RND_W-1:0] rnd_ff, rnd_in;
   logic          sel_ff, sel_in;
   logic          dups_ff, dups_in;
   logic          ok_ff, ok_in;
   logic [CW-1:0] i_ff, i_in;
   logic [CW-1:0] a_ff, a_in;
   logic [CW-1:0] c_ff, c_in;
   logic [CW-1:0] mid_ff, mid_in;
   logic [CW-1:0] hi_ff, hi_in;
   logic [CW-1:0] lo_ff, lo_in;
   logic [CW-1:0] w_ff, w_in;
   logic [LW-1:0] rank_ff, rank_in;
   logic [EW-1:0] prev_ff, prev_in;
   logic [EW-1:0] ent_ff, ent_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_kind_ff, rsp_kind_in;
   logic [POS_W-1:0] rsp_start_ff, rsp_start_in;
   logic          rsp_err_ff, rsp_err_in;

   // memory ports
   logic              txt_we;
   logic [AW-1:0]     txt_waddr, txt_ra0, txt_ra1;
   logic [BYTE_W-1:0] txt_wdata, txt_rd0, txt_rd1;
   logic              ent_we, ent_wsel;
   logic [AW-1:0]     ent_waddr, ent_ra0, ent_ra1;
   logic [EW-1:0]     ent_wdata, e0_rd0, e0_rd1, e1_rd0, e1_rd1, rd0, rd1;
   logic              rk_we;
   logic [AW-1:0]     rk_waddr, rk_ra0, rk_ra1;
   logic [LW-1:0]     rk_wdata, rk_rd0, rk_rd1;

   logic [EW-1:0]     cmp_a, cmp_b;
   cmp_res_type       cmp_res;

   logic          req_fire;
   logic [CW-1:0] n_c;
   logic [CW-1:0] two_w;
   logic [CW-1:0] sum_lw, sum_l2w;
   logic [CW-1:0] start_c, far_c;
   logic [LW-1:0] len_base;
   logic          dups_now;

   sab_ram #(.WIDTH(BYTE_W), .DEPTH(MAX_LEN)) u_text (
      .clock(clock), .we(txt_we), .waddr(txt_waddr), .wdata(txt_wdata),
      .raddr0(txt_ra0), .raddr1(txt_ra1), .rdata0(txt_rd0), .rdata1(txt_rd1)
   );

   sab_ram #(.WIDTH(EW), .DEPTH(MAX_LEN)) u_ent0 (
      .clock(clock), .we(ent_we && !ent_wsel), .waddr(ent_waddr), .wdata(ent_wdata),
      .raddr0(ent_ra0), .raddr1(ent_ra1), .rdata0(e0_rd0), .rdata1(e0_rd1)
   );

   sab_ram #(.WIDTH(EW), .DEPTH(MAX_LEN)) u_ent1 (
      .clock(clock), .we(ent_we && ent_wsel), .waddr(ent_waddr), .wdata(ent_wdata),
      .raddr0(ent_ra0), .raddr1(ent_ra1), .rdata0(e1_rd0), .rdata1(e1_rd1)
   );

   sab_ram #(.WIDTH(LW), .DEPTH(MAX_LEN)) u_rank (
      .clock(clock), .we(rk_we), .waddr(rk_waddr), .wdata(rk_wdata),
      .raddr0(rk_ra0), .raddr1(rk_ra1), .rdata0(rk_rd0), .rdata1(rk_rd1)
   );

   sab_cmp #(.EW(EW), .AW(AW)) u_cmp (
      .a(cmp_a), .b(cmp_b), .res(cmp_res)
   );

   assign req_ch.ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign req_fire = req_ch.valid && req_ch.ready;

   assign rd0 = sel_ff ? e1_rd0 : e0_rd0;
   assign rd1 = sel_ff ? e1_rd1 : e0_rd1;

   // merge compares right head against left head; ranking compares with the previous entry
   assign cmp_a = (state_ff == S_M_WR) ? rd1 : rd0;
   assign cmp_b = (state_ff == S_M_WR) ? rd0 : prev_ff;

   assign n_c = CW'(len_ff);
   assign two_w = w_ff << 1;
   assign sum_lw = lo_ff + w_ff;
   assign sum_l2w = lo_ff + two_w;
   assign start_c = CW'(ent_ff[AW-1:0]);
   assign far_c = start_c + gap_ff;
   assign len_base = built_ff ? '0 : len_ff;
   assign dups_now = dups_ff || ((i_ff != '0) && cmp_res.pair_eq);

   always_comb begin
      state_in = state_ff;
      len_in = len_ff;
      ovf_in = ovf_ff;
      built_in = built_ff;
      gap_in = gap_ff;
      rnd_in = rnd_ff;
      sel_in = sel_ff;
      dups_in = dups_ff;
      ok_in = ok_ff;
      i_in = i_ff;
      a_in = a_ff;
      c_in = c_ff;
      mid_in = mid_ff;
      hi_in = hi_ff;
      lo_in = lo_ff;
      w_in = w_ff;
      rank_in = rank_ff;
      prev_in = prev_ff;
      ent_in = ent_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_kind_in = rsp_kind_ff;
      rsp_start_in = rsp_start_ff;
      rsp_err_in = rsp_err_ff;

      txt_we = 1'b0;
      txt_waddr = AW'(len_base);
      txt_wdata = req_ch.text_byte;
      txt_ra0 = AW'(i_ff);
      txt_ra1 = AW'(i_ff + CW'(1));
      ent_we = 1'b0;
      ent_wsel = sel_ff;
      ent_waddr = AW'(i_ff);
      ent_wdata = rd0;
      ent_ra0 = AW'(i_ff);
      ent_ra1 = AW'(c_ff);
      rk_we = 1'b0;
      rk_waddr = rd0[AW-1:0];
      rk_wdata = rank_ff;
      rk_ra0 = ent_ff[AW-1:0];
      rk_ra1 = AW'(far_c);

      unique case (state_ff)
         S_IDLE: begin
            ent_ra0 = AW'(req_ch.position);
            if (req_fire) begin
               if (req_ch.action == ACT_READ) begin
                  ok_in = built_ff && (32'(req_ch.position) < 32'(len_ff));
                  state_in = S_RDWAIT;
               end else begin
                  if (built_ff) begin
                     ovf_in = 1'b0;
                     rnd_in = '0;
                     gap_in = CW'(2);
                     built_in = 1'b0;
                  end
                  if (32'(len_base) < 32'(MAX_LEN)) begin
                     txt_we = 1'b1;
                     len_in = len_base + LW'(1);
                  end else begin
                     len_in = len_base;
                     ovf_in = 1'b1;
                  end
                  if (req_ch.last) begin
                     gap_in = CW'(2);
                     rnd_in = '0;
                     sel_in = 1'b0;
                     i_in = '0;
                     state_in = S_INIT_RD;
                  end
               end
            end
         end
         S_RDWAIT: begin
            rsp_valid_in = 1'b1;
            rsp_kind_in = KIND_READ;
            rsp_start_in = ok_ff ? POS_W'(rd0[AW-1:0]) : '0;
            rsp_err_in = !ok_ff;
            state_in = S_IDLE;
         end
         S_INIT_RD: begin
            state_in = S_INIT_WR;
         end
         S_INIT_WR: begin
            ent_we = 1'b1;
            ent_wsel = 1'b0;
            ent_wdata = {LW'(txt_rd0),
                         ((i_ff + CW'(1)) < n_c) ? LW'(txt_rd1) : LW'(0),
                         AW'(i_ff)};
            i_in = i_ff + CW'(1);
            if ((i_ff + CW'(1)) == n_c) begin
               w_in = CW'(1);
               lo_in = '0;
               state_in = S_SORT;
            end else begin
               state_in = S_INIT_RD;
            end
         end
         S_SORT: begin
            priority if (w_ff >= n_c) begin
               i_in = '0;
               dups_in = 1'b0;
               state_in = S_R_RD;
            end else if (lo_ff >= n_c) begin
               w_in = two_w;
               lo_in = '0;
               sel_in = !sel_ff;
            end else begin
               mid_in = (sum_lw < n_c) ? sum_lw : n_c;
               hi_in = (sum_l2w < n_c) ? sum_l2w : n_c;
               a_in = lo_ff;
               c_in = (sum_lw < n_c) ? sum_lw : n_c;
               i_in = lo_ff;
               state_in = S_M_RD;
            end
         end
         S_M_RD: begin
            ent_ra0 = AW'(a_ff);
            ent_ra1 = AW'(c_ff);
            state_in = S_M_WR;
         end
         S_M_WR: begin
            ent_we = 1'b1;
            ent_wsel = !sel_ff;
            // right run wins only when strictly smaller or the left run is spent
            if ((c_ff < hi_ff) && ((a_ff >= mid_ff) || cmp_res.less)) begin
               ent_wdata = rd1;
               c_in = c_ff + CW'(1);
            end else begin
               ent_wdata = rd0;
               a_in = a_ff + CW'(1);
            end
            i_in = i_ff + CW'(1);
            if ((i_ff + CW'(1)) == hi_ff) begin
               lo_in = sum_l2w;
               state_in = S_SORT;
            end else begin
               state_in = S_M_RD;
            end
         end
         S_R_RD: begin
            state_in = S_R_WR;
         end
         S_R_WR: begin
            rk_we = 1'b1;
            rk_waddr = rd0[AW-1:0];
            if (i_ff == '0) begin
               rk_wdata = LW'(1);
            end else if (cmp_res.pair_eq) begin
               rk_wdata = rank_ff;
            end else begin
               rk_wdata = rank_ff + LW'(1);
            end
            rank_in = rk_wdata;
            dups_in = dups_now;
            prev_in = rd0;
            i_in = i_ff + CW'(1);
            if ((i_ff + CW'(1)) == n_c) begin
               if (rnd_ff != RND_MAX) begin
                  rnd_in = rnd_ff + RND_W'(1);
               end
               if (!dups_now || (gap_ff >= n_c)) begin
                  state_in = S_DONE;
               end else begin
                  i_in = '0;
                  state_in = S_F_RD;
               end
            end else begin
               state_in = S_R_RD;
            end
         end
         S_F_RD: begin
            state_in = S_F_RK;
         end
         S_F_RK: begin
            ent_in = rd0;
            rk_ra0 = rd0[AW-1:0];
            rk_ra1 = AW'(CW'(rd0[AW-1:0]) + gap_ff);
            state_in = S_F_WR;
         end
         S_F_WR: begin
            ent_we = 1'b1;
            ent_wsel = sel_ff;
            ent_wdata = {rk_rd0, (far_c < n_c) ? rk_rd1 : LW'(0), ent_ff[AW-1:0]};
            i_in = i_ff + CW'(1);
            if ((i_ff + CW'(1)) == n_c) begin
               gap_in = gap_ff << 1;
               w_in = CW'(1);
               lo_in = '0;
               state_in = S_SORT;
            end else begin
               state_in = S_F_RD;
            end
         end
         S_DONE: begin
            built_in = 1'b1;
            rsp_valid_in = 1'b1;
            rsp_kind_in = KIND_REPORT;
            rsp_start_in = '0;
            rsp_err_in = ovf_ff;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         len_ff <= '0;
         ovf_ff <= 1'b0;
         built_ff <= 1'b0;
         gap_ff <= CW'(2);
         rnd_ff <= '0;
         sel_ff <= 1'b0;
         dups_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         len_ff <= len_in;
         ovf_ff <= ovf_in;
         built_ff <= built_in;
         gap_ff <= gap_in;
         rnd_ff <= rnd_in;
         sel_ff <= sel_in;
         dups_ff <= dups_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ok_ff <= ok_in;
      i_ff <= i_in;
      a_ff <= a_in;
      c_ff <= c_in;
      mid_ff <= mid_in;
      hi_ff <= hi_in;
      lo_ff <= lo_in;
      w_ff <= w_in;
      rank_ff <= rank_in;
      prev_ff <= prev_in;
      ent_ff <= ent_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_start_ff <= rsp_start_in;
      rsp_err_ff <= rsp_err_in;
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.result_kind = rsp_kind_ff;
   assign rsp_ch.suffix_start = rsp_start_ff;
   assign rsp_ch.text_length = LEN_W'(len_ff);
   assign rsp_ch.rounds = rnd_ff;
   assign rsp_ch.error = rsp_err_ff;

   a_busy_no_accept: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_ch.ready)
      else $error("transaction accepted during build");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      32'(len_ff) <= 32'(MAX_LEN))
      else $error("length beyond capacity");

   a_merge_in_run: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_M_WR) |-> ((i_ff < hi_ff) && (hi_ff <= n_c)))
      else $error("merge output outside its run");

   a_report_after_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) |=> (rsp_valid_ff && built_ff))
      else $error("build finished without report");
endmodule

>>> tb/suffix_array_builder_test.sv
// self-checking testbench for the suffix array builder: text builds, sorted reads, errors
module suffix_array_builder_test;
   import sab_pkg::*;

   localparam int TEXT_MAX = 4096;
   localparam int RANDOM_ITEMS = 1350;
   localparam longint CYCLE_LIMIT = 30000000;

   typedef struct packed {
      logic kind;
      logic [POS_W-1:0] start;
      logic [LEN_W-1:0] length;
      logic [RND_W-1:0] rounds;
      logic error;
   } sab_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sab_req_if req_ch();
   sab_rsp_if rsp_ch();

   suffix_array_builder uut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // predictor state
   logic [BYTE_W-1:0] text_bytes [TEXT_MAX];
   logic [POS_W-1:0] sorted_starts [TEXT_MAX];
   int text_len = 0;
   bit text_dropped = 0;
   int build_rounds = 0;
   bit text_built = 0;

   sab_result_type pending_results[$];
   int mismatches = 0;
   int items_sent = 0;
   int builds_done = 0;
   int reads_done = 0;
   int error_results = 0;
   longint cycle_count = 0;
   bit idling_on = 1;

   // prefix doubling on the predictor's copy of the text
   task automatic sort_suffixes();
      int unsigned first_key [TEXT_MAX];
      int unsigned second_key [TEXT_MAX];
      int unsigned rank_of [TEXT_MAX];
      longint unsigned keys[$];
      int gap;
      int cur;
      bit dups;
      int s;
      build_rounds = 0;
      gap = 2;
      for (int i = 0; i < text_len; i++) begin
         first_key[i] = 32'(text_bytes[i]);
         second_key[i] = (i + 1 < text_len) ? 32'(text_bytes[i + 1]) : 0;
      end
      forever begin
         keys.delete();
         for (int i = 0; i < text_len; i++)
            keys.push_back({26'd0, first_key[i][12:0], second_key[i][12:0], i[11:0]});
         keys.sort();
         if (build_rounds < 15) build_rounds++;
         cur = 1;
         dups = 0;
         for (int k = 0; k < text_len; k++) begin
            if (k > 0) begin
               if (keys[k][37:12] == keys[k-1][37:12]) dups = 1;
               else cur++;
            end
            sorted_starts[k] = keys[k][11:0];
            rank_of[keys[k][11:0]] = cur;
         end
         if (!dups || gap >= text_len) break;
         for (int i = 0; i < text_len; i++) begin
            first_key[i] = rank_of[i];
            second_key[i] = (i + gap < text_len) ? rank_of[i + gap] : 0;
         end
         gap *= 2;
      end
   endtask

   task automatic predict(input logic act, input logic [BYTE_W-1:0] b, input logic lst,
                          input logic [POS_W-1:0] pos);
      sab_result_type r;
      bit ok;
      if (act == ACT_APPEND) begin
         if (text_built) begin
            text_len = 0;
            text_dropped = 0;
            build_rounds = 0;
            text_built = 0;
         end
         if (text_len < TEXT_MAX) begin
            text_bytes[text_len] = b;
            text_len++;
         end else
            text_dropped = 1;
         if (!lst) return;
         sort_suffixes();
         text_built = 1;
         r.kind = KIND_REPORT;
         r.start = '0;
         r.length = LEN_W'(text_len);
         r.rounds = RND_W'(build_rounds);
         r.error = text_dropped;
      end else begin
         ok = text_built && pos < text_len;
         r.kind = KIND_READ;
         r.start = ok ? sorted_starts[pos] : '0;
         r.length = LEN_W'(text_len);
         r.rounds = RND_W'(build_rounds);
         r.error = !ok;
      end
      pending_results.push_back(r);
   endtask

   task automatic idle_cycles(input int n);
      req_ch.valid <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   // drive one transaction, return at the falling edge after acceptance
   task automatic send_item(input logic act, input logic [BYTE_W-1:0] b, input logic lst,
                            input logic [POS_W-1:0] pos);
      if (idling_on && $urandom_range(0, 5) == 0) idle_cycles($urandom_range(1, 16));
      req_ch.valid <= 1'b1;
      req_ch.action <= act;
      req_ch.text_byte <= b;
      req_ch.last <= lst;
      req_ch.position <= pos;
      do @(posedge clock); while (!req_ch.ready);
      predict(act, b, lst, pos);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic load_text(input logic [BYTE_W-1:0] txt[$], input bit with_noise);
      foreach (txt[i]) begin
         if (with_noise && i > 0 && $urandom_range(0, 15) == 0)
            send_item(ACT_READ, BYTE_W'($urandom), 1'($urandom), POS_W'($urandom));
         send_item(ACT_APPEND, txt[i], i == txt.size() - 1, POS_W'($urandom));
      end
   endtask

   task automatic drain();
      idle_cycles(1);
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   task automatic test_reads_before_build();
      send_item(ACT_READ, 8'h00, 1'b0, 12'd0);
      send_item(ACT_READ, 8'hFF, 1'b1, 12'hFFF);
   endtask

   task automatic test_edge_texts();
      logic [BYTE_W-1:0] txt[$];
      txt = '{8'hFF};
      load_text(txt, 0);
      send_item(ACT_READ, 8'h00, 1'b0, 12'd0);
      send_item(ACT_READ, 8'h00, 1'b1, 12'd1);
      // zero bytes tie with the past-end key and never separate
      txt = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
      load_text(txt, 0);
      for (int p = 0; p < 5; p++) send_item(ACT_READ, 8'h00, 1'b0, POS_W'(p));
      txt = '{8'h61, 8'h61, 8'h61, 8'h61, 8'h61, 8'hFF, 8'h00, 8'h61};
      load_text(txt, 0);
      send_item(ACT_READ, 8'h00, 1'b0, 12'd7);
      send_item(ACT_READ, 8'h00, 1'b0, 12'd8);
      drain();
   endtask

   task automatic test_capacity_overflow();
      logic [BYTE_W-1:0] txt[$];
      for (int i = 0; i < TEXT_MAX + 3; i++) txt.push_back(BYTE_W'($urandom));
      load_text(txt, 0);
      send_item(ACT_READ, 8'h00, 1'b0, 12'd0);
      send_item(ACT_READ, 8'h00, 1'b0, 12'hFFF);
      for (int k = 0; k < 6; k++) send_item(ACT_READ, 8'h00, 1'b0, POS_W'($urandom));
      drain();
   endtask

   task automatic test_random_builds();
      logic [BYTE_W-1:0] txt[$];
      int n;
      int nreads;
      bit narrow;
      while (items_sent < RANDOM_ITEMS + TEXT_MAX + 40) begin
         if (items_sent > RANDOM_ITEMS + TEXT_MAX - 200) idling_on = 0;
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 160) : $urandom_range(1, 24);
         narrow = $urandom_range(0, 1);
         txt.delete();
         for (int i = 0; i < n; i++)
            txt.push_back(narrow ? BYTE_W'($urandom_range(0, 2)) : BYTE_W'($urandom));
         load_text(txt, 1);
         nreads = $urandom_range(1, n + 3);
         for (int k = 0; k < nreads; k++)
            send_item(ACT_READ, BYTE_W'($urandom), 1'($urandom),
                      ($urandom_range(0, 7) == 0) ? POS_W'($urandom)
                                                  : POS_W'($urandom_range(0, n + 1)));
         if ($urandom_range(0, 9) == 0) drain();
      end
   endtask

   // result sink stalls in random bursts
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (idling_on && $urandom_range(0, 7) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      sab_result_type got;
      sab_result_type want;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("** suffix_array_builder: FAILED **");
         $finish;
      end
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = '{rsp_ch.result_kind, rsp_ch.suffix_start, rsp_ch.text_length,
                 rsp_ch.rounds, rsp_ch.error};
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result transaction %p", got);
         end else begin
            want = pending_results.pop_front();
            if (got.kind == KIND_REPORT) builds_done++;
            else reads_done++;
            if (got.error) error_results++;
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %p, got %p", want, got);
            end
         end
      end
   end

   initial begin
      req_ch.valid = 1'b0;
      req_ch.action = ACT_APPEND;
      req_ch.text_byte = '0;
      req_ch.last = 1'b0;
      req_ch.position = '0;
      reset = 1'b1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_reads_before_build();
      test_edge_texts();
      test_capacity_overflow();
      test_random_builds();
      drain();
      repeat (200) @(negedge clock);
      $display("covered %0d transactions: %0d builds, %0d reads, %0d error results",
               items_sent, builds_done, reads_done, error_results);
      $display("texts of 1 to 160 bytes plus one past capacity, %0d mismatches", mismatches);
      if (mismatches == 0 && pending_results.size() == 0)
         $display("** suffix_array_builder: PASSED **");
      else
         $display("** suffix_array_builder: FAILED **");
      $finish;
   end

endmodule
